// File: src/uart_baud_divisor_calc_defines.svh
// assertion macros for the baud divisor checker
`ifndef UART_BAUD_DIVISOR_CALC_DEFINES_SVH
`define UART_BAUD_DIVISOR_CALC_DEFINES_SVH

// same-cycle implication, off during reset
`define UBD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ubd check failed");

// next-cycle implication, off during reset
`define UBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ubd check failed");

// next-cycle implication, also active in reset
`define UBD_ASSERT_NEXT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("ubd reset check failed");

`endif

// File: src/ubd_pkg.sv
package ubd_pkg;

    localparam int CLOCK_BITS = 26;
    localparam int CFG_W      = 26;
    localparam int BAUD_W     = 24;
    localparam int CMP_W      = BAUD_W + 4;
    localparam int NUM_W      = CLOCK_BITS + 6;
    localparam int DEN_W      = BAUD_W + 2;
    localparam int DIV_STAGES = NUM_W;
    localparam int FRAC_W     = 6;
    localparam int INT_W      = 22;
    localparam int DIV_W      = INT_W + FRAC_W;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 3;

    localparam logic [CLOCK_BITS-1:0] CLOCK_RESET = CLOCK_BITS'(32000000);

    typedef enum logic [1:0] {
        MODE_16X = 2'd0,
        MODE_8X  = 2'd1,
        MODE_3X  = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic              err;
        logic [DEN_W-1:0]  den;
        logic [DEN_W-1:0]  rem;
        logic [NUM_W-1:0]  nq;
    } div_stage_t;

    typedef struct packed {
        logic [OUT_TUSER_W-1:0] tuser;
        logic [OUT_TDATA_W-1:0] tdata;
    } out_beat_t;

endpackage

// File: src/ubd_prep.sv
module ubd_prep (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [ubd_pkg::BAUD_W-1:0]        baud,
    input  logic [ubd_pkg::CLOCK_BITS-1:0]    clock_hz,
    output logic                              out_valid,
    output ubd_pkg::div_stage_t               out_data
);

    logic                     valid_reg;
    ubd_pkg::div_stage_t      data_reg;
    ubd_pkg::div_stage_t      data_next;
    logic [ubd_pkg::CMP_W-1:0] clk_ext;
    logic [ubd_pkg::CMP_W-1:0] baud_x8;
    logic [ubd_pkg::CMP_W-1:0] baud_x16;
    logic [ubd_pkg::BAUD_W-1:0] baud_sel;

    always_comb begin
        clk_ext  = ubd_pkg::CMP_W'(clock_hz);
        baud_x8  = {1'b0, baud, 3'b000};
        baud_x16 = {baud, 4'b0000};
        baud_sel = baud;
        data_next.rem = '0;
        if (baud_x8 > clk_ext) begin
            data_next.mode = ubd_pkg::MODE_3X;
            data_next.err  = 1'b0;
            data_next.nq   = {clock_hz, 6'b000000};
            data_next.den  = {2'b00, baud} + {1'b0, baud, 1'b0};
        end else begin
            if (baud_x16 > clk_ext) begin
                data_next.mode = ubd_pkg::MODE_8X;
                baud_sel       = {1'b0, baud[ubd_pkg::BAUD_W-1:1]};
            end else begin
                data_next.mode = ubd_pkg::MODE_16X;
            end
            data_next.err = (baud_sel == '0);
            data_next.nq  = {3'b000, clock_hz, 3'b000};
            data_next.den = {2'b00, baud_sel};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: src/ubd_div_stage.sv
module ubd_div_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  ubd_pkg::div_stage_t  in_data,
    output logic                 out_valid,
    output ubd_pkg::div_stage_t  out_data
);

    logic                         valid_reg;
    ubd_pkg::div_stage_t          data_reg;
    ubd_pkg::div_stage_t          data_next;
    logic [ubd_pkg::DEN_W:0]      trial;
    logic [ubd_pkg::DEN_W:0]      diff;
    logic                         fits;

    // one restoring step: shift in the next numerator bit, subtract if it fits
    always_comb begin
        trial = {in_data.rem, in_data.nq[ubd_pkg::NUM_W-1]};
        fits  = (trial >= {1'b0, in_data.den});
        diff  = trial - {1'b0, in_data.den};
        data_next      = in_data;
        data_next.rem  = fits ? diff[ubd_pkg::DEN_W-1:0] : trial[ubd_pkg::DEN_W-1:0];
        data_next.nq   = {in_data.nq[ubd_pkg::NUM_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: src/ubd_out.sv
module ubd_out (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    input  ubd_pkg::div_stage_t                  in_data,
    output logic                                 en,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [ubd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic [ubd_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);

    logic                                        out_v_reg;
    logic                                        out_v_next;
    logic                                        sk_v_reg;
    logic                                        sk_v_next;
    ubd_pkg::out_beat_t                          out_d_reg;
    ubd_pkg::out_beat_t                          out_d_next;
    ubd_pkg::out_beat_t                          sk_d_reg;
    ubd_pkg::out_beat_t                          sk_d_next;
    ubd_pkg::out_beat_t                          res;
    logic [ubd_pkg::NUM_W:0]                     rounded;
    logic [ubd_pkg::NUM_W+ubd_pkg::DIV_W-1:0]    picked;
    logic [ubd_pkg::DIV_W-1:0]                   divisor;

    // round to nearest for 16x and 8x, plain quotient for 3x
    always_comb begin
        rounded = {1'b0, in_data.nq} + (ubd_pkg::NUM_W + 1)'(1);
        if (in_data.mode == ubd_pkg::MODE_3X) begin
            picked = {ubd_pkg::DIV_W'(0), in_data.nq};
        end else begin
            picked = {ubd_pkg::DIV_W'(0), rounded[ubd_pkg::NUM_W:1]};
        end
        divisor = in_data.err ? '0 : picked[ubd_pkg::DIV_W-1:0];
        res.tuser = {in_data.err, in_data.mode};
        res.tdata = {(ubd_pkg::OUT_TDATA_W - ubd_pkg::DIV_W)'(0),
                     divisor[ubd_pkg::FRAC_W-1:0],
                     divisor[ubd_pkg::DIV_W-1:ubd_pkg::FRAC_W]};
    end

    // output register plus skid slot
    always_comb begin
        out_v_next = out_v_reg;
        out_d_next = out_d_reg;
        sk_v_next  = sk_v_reg;
        sk_d_next  = sk_d_reg;
        if (!out_v_reg || m_axis_tready) begin
            if (sk_v_reg) begin
                out_v_next = 1'b1;
                out_d_next = sk_d_reg;
                sk_v_next  = 1'b0;
            end else begin
                out_v_next = in_valid;
                out_d_next = res;
            end
        end else if (!sk_v_reg && in_valid) begin
            sk_v_next = 1'b1;
            sk_d_next = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
            sk_v_reg  <= 1'b0;
        end else begin
            out_v_reg <= out_v_next;
            sk_v_reg  <= sk_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_d_reg <= out_d_next;
        sk_d_reg  <= sk_d_next;
    end

    assign en            = !sk_v_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_d_reg.tdata;
    assign m_axis_tuser  = out_d_reg.tuser;

endmodule

// File: src/uart_baud_divisor_calc.sv
// uart baud divisor calculator
// s_axis carries one requested baud rate per transfer; m_axis returns one
// result per transfer, in order: oversampling mode and error flag on tuser,
// integer and fractional divisor on tdata.
// cfg_we/cfg_wdata load the functional clock frequency; write it only while
// no request is in flight.
// pipeline: one setup stage, one restoring divider stage per numerator
// bit, one rounding/output register.
// throughput: one transfer per cycle while s_axis_tready is high; every
// divider stage is its own register stage, so a new request enters
// each cycle.
// reset clears all valid bits and loads the clock register with 32 MHz;
// s_axis_tready is high from the first cycle after reset.
// when m_axis_tready is low the finished result holds and one more result
// parks in a skid slot; only once that slot is full does s_axis_tready
// drop and the whole pipeline freeze without loss.
module uart_baud_divisor_calc (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [ubd_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ubd_pkg::BAUD_W-1:0]         s_axis_tdata,  // baud_rate
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // divisor_integer, divisor_fraction, zero pad
    output logic [ubd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // oversample_mode, divide_error
    output logic [ubd_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

    logic [ubd_pkg::CLOCK_BITS-1:0] clock_hz_reg;
    logic                           pipe_en;
    logic [ubd_pkg::DIV_STAGES:0]   stage_valid;
    ubd_pkg::div_stage_t            stage_data [ubd_pkg::DIV_STAGES+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= ubd_pkg::CLOCK_RESET;
        end else if (cfg_we) begin
            clock_hz_reg <= cfg_wdata[ubd_pkg::CLOCK_BITS-1:0];
        end
    end

    ubd_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_axis_tvalid),
        .baud      (s_axis_tdata),
        .clock_hz  (clock_hz_reg),
        .out_valid (stage_valid[0]),
        .out_data  (stage_data[0])
    );

    for (genvar k = 0; k < ubd_pkg::DIV_STAGES; k++) begin : g_div
        ubd_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (stage_valid[k]),
            .in_data   (stage_data[k]),
            .out_valid (stage_valid[k+1]),
            .out_data  (stage_data[k+1])
        );
    end

    ubd_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (stage_valid[ubd_pkg::DIV_STAGES]),
        .in_data       (stage_data[ubd_pkg::DIV_STAGES]),
        .en            (pipe_en),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    assign s_axis_tready = pipe_en;

endmodule

// File: src/ubd_checker.sv
`include "uart_baud_divisor_calc_defines.svh"

module ubd_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [ubd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic [ubd_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

    // a stalled result transfer keeps its payload
    `UBD_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // an error result carries zero divisors
    `UBD_ASSERT_NOW(a_err_zero, m_axis_tvalid && m_axis_tuser[2], m_axis_tdata[ubd_pkg::DIV_W-1:0] == '0)

    // 3x mode never flags an error
    `UBD_ASSERT_NOW(a_3x_no_err, m_axis_tvalid && (m_axis_tuser[1:0] == ubd_pkg::MODE_3X), !m_axis_tuser[2])

    // reset empties the output
    `UBD_ASSERT_NEXT_RST(a_rst_empty, !aresetn, !m_axis_tvalid)

endmodule

bind uart_baud_divisor_calc ubd_checker u_ubd_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ubd_pkg::*;

    typedef struct packed {
        mode_t             mode;
        logic [INT_W-1:0]  dint;
        logic [FRAC_W-1:0] dfrac;
        logic              err;
    } baud_result_t;

    typedef struct packed {
        logic              wr_clk;
        logic [CFG_W-1:0]  clk;
        logic [BAUD_W-1:0] baud;
        logic              typed;
        baud_result_t      res;
    } baud_row_t;

    localparam logic [CFG_W-1:0]  CLK_MAX  = 26'h3FFFFFF;
    localparam logic [BAUD_W-1:0] BAUD_MAX = 24'hFFFFFF;
    localparam int                N_ROWS   = 20;
    localparam int                N_PHASES = 8;
    localparam int                RESULT_LATENCY = CLOCK_BITS + 8;

    localparam baud_row_t BAUD_ROWS [N_ROWS] = '{
        '{1'b0, 26'd0, 24'd0, 1'b1, '{MODE_16X, 22'd0, 6'd0, 1'b1}},
        '{1'b0, 26'd0, 24'd1, 1'b1, '{MODE_16X, 22'd2000000, 6'd0, 1'b0}},
        '{1'b0, 26'd0, BAUD_MAX, 1'b1, '{MODE_3X, 22'd0, 6'd40, 1'b0}},
        '{1'b0, 26'd0, 24'd115200, 1'b0, '0},
        '{1'b0, 26'd0, 24'd9600, 1'b0, '0},
        '{1'b0, 26'd0, 24'd4000000, 1'b0, '0},
        '{1'b0, 26'd0, 24'd4000001, 1'b0, '0},
        '{1'b0, 26'd0, 24'd2000000, 1'b0, '0},
        '{1'b0, 26'd0, 24'd2000001, 1'b0, '0},
        '{1'b1, CLK_MAX, 24'd1, 1'b1, '{MODE_16X, 22'd4194303, 6'd60, 1'b0}},
        '{1'b0, 26'd0, BAUD_MAX, 1'b0, '0},
        '{1'b0, 26'd0, 24'd0, 1'b1, '{MODE_16X, 22'd0, 6'd0, 1'b1}},
        '{1'b1, 26'd0, 24'd0, 1'b1, '{MODE_16X, 22'd0, 6'd0, 1'b1}},
        '{1'b0, 26'd0, 24'd5, 1'b1, '{MODE_3X, 22'd0, 6'd0, 1'b0}},
        '{1'b1, 26'd8, 24'd1, 1'b1, '{MODE_8X, 22'd0, 6'd0, 1'b1}},
        '{1'b0, 26'd0, 24'd2, 1'b0, '0},
        '{1'b0, 26'd0, BAUD_MAX, 1'b0, '0},
        '{1'b1, 26'd1, 24'd1, 1'b0, '0},
        '{1'b1, 26'd15, 24'd1, 1'b1, '{MODE_8X, 22'd0, 6'd0, 1'b1}},
        '{1'b0, 26'd0, 24'd0, 1'b1, '{MODE_16X, 22'd0, 6'd0, 1'b1}}
    };

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_W-1:0]       cfg_wdata     = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [BAUD_W-1:0]      s_axis_tdata  = '0;  // baud_rate
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // divisor_integer, divisor_fraction, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // oversample_mode, divide_error
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    logic [CFG_W-1:0] clock_setting = CLOCK_RESET;
    baud_result_t     pending_divisors [$];
    baud_result_t     oldest_divisor;
    int               mismatches = 0;

    int               ready_style = 0;
    int               style_left  = 0;
    int               hold_left   = 0;
    int               taken       = 0;
    bit               held        = 1'b0;

    uart_baud_divisor_calc dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic baud_result_t calc_divisor(logic [CFG_W-1:0] clk,
                                                  logic [BAUD_W-1:0] baud_in);
        logic [63:0]  c;
        logic [63:0]  b;
        logic [63:0]  d;
        baud_result_t r;
        c = 64'(clk);
        b = 64'(baud_in);
        d = '0;
        r = '0;
        if (b * 8 > c) begin
            r.mode = MODE_3X;
            d = (c * 64) / (b * 3);
        end else begin
            if (b * 16 > c) begin
                r.mode = MODE_8X;
                b = b >> 1;
            end else begin
                r.mode = MODE_16X;
            end
            if (b == 0) begin
                r.err = 1'b1;
            end else begin
                d = ((c * 8) / b + 1) >> 1;
            end
        end
        r.dint  = d[27:6];
        r.dfrac = d[5:0];
        return r;
    endfunction

    function automatic logic [BAUD_W-1:0] pick_baud(logic [CFG_W-1:0] clk);
        logic [63:0] v;
        int          off;
        off = $urandom_range(0, 4);
        case ($urandom_range(0, 5))
            0: v = 64'($urandom_range(0, 32'hFFFFFF));
            1: v = 64'($urandom_range(0, 3));
            2: v = 64'(clk / 16) + 64'(off);
            3: v = 64'(clk / 8) + 64'(off);
            4: v = 64'($urandom_range(0, 32'(clk / 16)));
            default: begin
                case ($urandom_range(0, 5))
                    0: v = 64'd9600;
                    1: v = 64'd19200;
                    2: v = 64'd57600;
                    3: v = 64'd115200;
                    4: v = 64'd921600;
                    default: v = 64'd3000000;
                endcase
            end
        endcase
        if (v >= 2 && (v - 2) < 64'(BAUD_MAX)) begin
            v = (off < 2 && $urandom_range(0, 1) == 1) ? v - 2 : v;
        end
        if (v > 64'(BAUD_MAX)) begin
            v = 64'(BAUD_MAX);
        end
        return v[BAUD_W-1:0];
    endfunction

    task automatic send_baud(logic [BAUD_W-1:0] baud, baud_result_t res);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= baud;
        do @(posedge aclk); while (!s_axis_tready);
        pending_divisors.push_back(res);
    endtask

    task automatic set_clock(logic [CFG_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_divisors.size() != 0) @(posedge aclk);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we        <= 1'b0;
        clock_setting  = value;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // result side: stalls in randomly chosen styles that change over the run,
    // plus one long hold so that the pipeline fills and back-pressures
    always @(posedge aclk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            taken++;
        end
        if (style_left == 0) begin
            ready_style = $urandom_range(0, 3);
            style_left  = $urandom_range(10, 60);
        end else begin
            style_left--;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!held && taken >= 80) begin
            held      = 1'b1;
            hold_left = 200;
            m_axis_tready <= 1'b0;
        end else begin
            case (ready_style)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_divisors.size() == 0) begin
                $error("result transfer with no request pending");
                mismatches++;
            end else begin
                oldest_divisor = pending_divisors.pop_front();
                check_field("oversample_mode", 32'(oldest_divisor.mode),
                            32'(m_axis_tuser[1:0]));
                check_field("divide_error", 32'(oldest_divisor.err),
                            32'(m_axis_tuser[2]));
                check_field("divisor_integer", 32'(oldest_divisor.dint),
                            32'(m_axis_tdata[21:0]));
                check_field("divisor_fraction", 32'(oldest_divisor.dfrac),
                            32'(m_axis_tdata[27:22]));
            end
        end
    end

    initial begin
        logic [CFG_W-1:0]  phase_clock;
        logic [BAUD_W-1:0] baud;
        int                burst_left;
        int                gap;
        int                items;
        int                guard;
        burst_left = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            if (BAUD_ROWS[i].wr_clk) begin
                set_clock(BAUD_ROWS[i].clk);
            end
            send_baud(BAUD_ROWS[i].baud, BAUD_ROWS[i].typed ? BAUD_ROWS[i].res :
                      calc_divisor(clock_setting, BAUD_ROWS[i].baud));
        end

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: phase_clock = CLOCK_RESET;
                1: phase_clock = CLK_MAX;
                2: phase_clock = CFG_W'($urandom_range(1, 4095));
                3: phase_clock = CFG_W'($urandom_range(1, 32'h3FFFFFF));
                4: phase_clock = '0;
                5: phase_clock = CFG_W'(1843200);
                6: phase_clock = CFG_W'($urandom_range(16, 200000));
                default: phase_clock = CFG_W'($urandom_range(1, 32'h3FFFFFF));
            endcase
            set_clock(phase_clock);
            items = (p == 0) ? 200 : 136;
            for (int n = 0; n < items; n++) begin
                baud = pick_baud(clock_setting);
                send_baud(baud, calc_divisor(clock_setting, baud));
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
                    gap        = $urandom_range(0, 8);
                    if (gap != 0) begin
                        s_axis_tvalid <= 1'b0;
                        repeat (gap) @(posedge aclk);
                    end
                end else begin
                    burst_left--;
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (pending_divisors.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        if (pending_divisors.size() != 0) begin
            $error("%0d results never arrived", pending_divisors.size());
            mismatches++;
        end
        repeat (RESULT_LATENCY + 16) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("status: fail");
        $finish;
    end

endmodule
